FILE: src/rfifo_pkg.sv
// ----------------------------------------------------------------------------
// rfifo_pkg
// shared types and constants for the ring fifo with overwriting push
// ----------------------------------------------------------------------------
`default_nettype none

package rfifo_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 8;
	localparam int IDX_BITS  = $clog2(DEPTH);
	localparam int CNT_BITS  = 5;

	// operation codes
	localparam logic [2:0] MODE_PUSH    = 3'd0;
	localparam logic [2:0] MODE_PUSH_OW = 3'd1;
	localparam logic [2:0] MODE_GET     = 3'd2;
	localparam logic [2:0] MODE_POP     = 3'd3;
	localparam logic [2:0] MODE_FLUSH   = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_OVWR  = 2'd3;

	typedef struct packed {
		logic [2:0]           mode;
		logic [WORD_BITS-1:0] data_in;
	} in_item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] data_out;
		logic [1:0]           status;
		logic [CNT_BITS-1:0]  count;
		logic                 is_empty;
		logic                 is_full;
	} out_item_t;

endpackage

`default_nettype wire

FILE: src/rfifo_ram.sv
// ----------------------------------------------------------------------------
// rfifo_ram
// simple dual-port ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rfifo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/ring_fifo_with_overwrite_top.sv
// ----------------------------------------------------------------------------
// ring_fifo_with_overwrite_top
// ring buffer fifo with selectable capacity, overwriting push and lifo pop
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_item) carries one operation per item:
//   push, push with overwrite, get oldest, pop newest or flush.
//   out channel (out_valid/out_ready/out_item) returns exactly one result
//   per item: word taken, status, count after the operation, empty/full.
//   cfg_wr_en/cfg_wr_data set the capacity in use (0 acts as 1, above 16
//   acts as 16) and empty the queue; write only while the block is idle.
// sequencing:
//   push, flush, unused codes and a get/pop on an empty queue: result is
//   in the output register in the cycle after acceptance.
//   get/pop on a non-empty queue: the storage ram registers the read
//   data, then the ST_READ state copies it into the output register.
//   one item is in flight at a time; a new item is accepted once the
//   output register is empty or being drained.
// reset: pointers and count clear, capacity returns to 16; ram contents
//   are left as they are.
// stall: while out_ready is low the result holds and in_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_with_overwrite_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [4:0]          cfg_wr_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire rfifo_pkg::in_item_t in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output rfifo_pkg::out_item_t     out_item
);

	import rfifo_pkg::*;

	// sequencer states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic                state_q;
	logic [CNT_BITS-1:0] cap_q;
	logic [IDX_BITS-1:0] head_q;
	logic [IDX_BITS-1:0] tail_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_valid_q;
	out_item_t           out_q;

	// effective capacity after clamping
	logic [CNT_BITS-1:0] cap_eff;
	logic [IDX_BITS-1:0] cap_last;

	// next-state values for the accepted item
	logic [IDX_BITS-1:0]  head_d;
	logic [IDX_BITS-1:0]  tail_d;
	logic [CNT_BITS-1:0]  cnt_d;
	logic [1:0]           stat_d;
	logic                 do_read;
	logic [IDX_BITS-1:0]  rd_addr;
	logic                 do_write;
	logic [WORD_BITS-1:0] rd_data;
	logic                 accept;
	logic                 full;
	logic                 empty;

	always_comb begin
		priority if (cap_q == '0) begin
			cap_eff = CNT_BITS'(1);
		end else if (cap_q > CNT_BITS'(DEPTH)) begin
			cap_eff = CNT_BITS'(DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign cap_last = IDX_BITS'(cap_eff - CNT_BITS'(1));

	// advance one slot with wrap at the capacity in use
	function automatic logic [IDX_BITS-1:0] ring_inc(
		input logic [IDX_BITS-1:0] idx,
		input logic [CNT_BITS-1:0] cap
	);
		logic [CNT_BITS-1:0] nxt;
		nxt = CNT_BITS'(idx) + CNT_BITS'(1);
		return (nxt >= cap) ? '0 : IDX_BITS'(nxt);
	endfunction

	assign full   = (cnt_q >= cap_eff);
	assign empty  = (cnt_q == '0);
	assign accept = in_valid && in_ready;

	// an item is taken only when nothing is in flight and the result slot frees up
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		stat_d   = STAT_OK;
		do_read  = 1'b0;
		do_write = 1'b0;
		rd_addr  = head_q;
		unique case (in_item.mode)
			MODE_PUSH: begin
				if (full) begin
					stat_d = STAT_FULL;
				end else begin
					do_write = 1'b1;
					tail_d   = ring_inc(tail_q, cap_eff);
					cnt_d    = cnt_q + CNT_BITS'(1);
				end
			end
			MODE_PUSH_OW: begin
				// when full the tail slot is the oldest entry, so head moves along
				do_write = 1'b1;
				tail_d   = ring_inc(tail_q, cap_eff);
				if (full) begin
					head_d = ring_inc(head_q, cap_eff);
					stat_d = STAT_OVWR;
				end else begin
					cnt_d = cnt_q + CNT_BITS'(1);
				end
			end
			MODE_GET: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					do_read = 1'b1;
					rd_addr = head_q;
					head_d  = ring_inc(head_q, cap_eff);
					cnt_d   = cnt_q - CNT_BITS'(1);
				end
			end
			MODE_POP: begin
				// tail steps back with wrap, then that slot is read
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					do_read = 1'b1;
					tail_d  = (tail_q == '0) ? cap_last : tail_q - IDX_BITS'(1);
					rd_addr = tail_d;
					cnt_d   = cnt_q - CNT_BITS'(1);
				end
			end
			MODE_FLUSH: begin
				head_d = tail_q;
				cnt_d  = '0;
			end
			default: begin
				// unused codes leave the queue untouched
			end
		endcase
	end

	// storage: writes and reads are issued only at acceptance, one item at a time,
	// so a read never overlaps a write to the same entry
	rfifo_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept && do_write),
		.waddr(tail_q),
		.wdata(in_item.data_in),
		.re   (accept && do_read),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// control and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CNT_BITS'(DEPTH);
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				// new ring size: empty the queue so both pointers stay inside it
				cap_q  <= cfg_wr_data;
				head_q <= '0;
				tail_q <= '0;
				cnt_q  <= '0;
			end else if (accept) begin
				head_q <= head_d;
				tail_q <= tail_d;
				cnt_q  <= cnt_d;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_valid_q <= !do_read;
						state_q     <= do_read ? ST_READ : ST_IDLE;
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_READ: begin
					// ram data is back: result complete
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.data_out <= '0;
			out_q.status   <= stat_d;
			out_q.count    <= cnt_d;
			out_q.is_empty <= (cnt_d == '0);
			out_q.is_full  <= (cnt_d >= cap_eff);
		end else if (state_q == ST_READ) begin
			out_q.data_out <= rd_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// count never goes past the ring in use
	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_eff)
		else $error("fill count above capacity");

	// both pointers stay inside the ring
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_BITS'(head_q) < cap_eff) && (CNT_BITS'(tail_q) < cap_eff))
		else $error("pointer outside ring");

	// a read in flight never shows a result before its data arrives
	a_read_hides_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (!out_valid_q && !in_ready))
		else $error("result visible while read pending");

	// an accepted get or pop on a non-empty queue goes to ST_READ to wait for the ram
	a_read_then_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && do_read) |=> (state_q == ST_READ))
		else $error("read did not wait for ram data");

	// a read completes into a valid result in the next cycle
	a_read_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("read result not delivered");

endmodule

`default_nettype wire
